### design/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, status codes and sequencer states of the first-fit heap
// allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 16;

  localparam int unsigned CMD_W    = 1;
  localparam int unsigned REQ_W    = 13;
  localparam int unsigned PTR_W    = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ADDR_W   = 12;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_ZERO      = 3'd2,
    STAT_NO_FIT    = 3'd3,
    STAT_NULL      = 3'd4,
    STAT_INVALID   = 3'd5,
    STAT_NOT_ALLOC = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_WNEW,
    S_F_CHK,
    S_F_RCHK,
    S_F_LREAD,
    S_F_LCHK,
    S_F_WM,
    S_FIX
  } state_t;

endpackage
`default_nettype wire

### design/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Errors found on entry strobe in the cycle after the accepting edge; an
// allocation reads the headers it visits in turn (S_A_CHK) and, when it splits
// a block, writes the new header (S_A_WNEW) and fixes the next prev (S_FIX); a
// free of a block not allocated strobes from S_F_CHK, others merge and write.
// One request in flight at a time; busy stays high until the result strobes.
// After reset a clearing pass writes every word of the header memory.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Boundary-tag heap manager: first-fit walk of the header chain, one header
// read per cycle from a single-port-write header memory, split and merge.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ffha_pkg::CMD_W-1:0]     in_command,
  input  wire logic [ffha_pkg::REQ_W-1:0]     in_request_size,
  input  wire logic [ffha_pkg::PTR_W-1:0]     in_pointer,
  output logic                                out_valid,
  output logic [ffha_pkg::STATUS_W-1:0]       out_status,
  output logic [ffha_pkg::ADDR_W-1:0]         out_address
);

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned EW = 2 * AW + 3;
  localparam int unsigned CW = (AW + 2 > 14) ? AW + 2 : 14;

  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_BYTES - 1);
  localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

  // header layout: start | alloc | last | size | prev
  localparam int unsigned B_START = 2 * AW + 2;
  localparam int unsigned B_ALLOC = 2 * AW + 1;
  localparam int unsigned B_LAST  = 2 * AW;

  logic [EW-1:0] mem [HEAP_BYTES];
  logic [EW-1:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  ffha_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [ffha_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [CW-1:0]    cur_r, cur_nxt;
  logic [CW-1:0]    meta_r, meta_nxt;
  logic [AW-1:0]    m_size_r, m_size_nxt;
  logic [AW-1:0]    m_prev_r, m_prev_nxt;
  logic             m_last_r, m_last_nxt;
  logic             right_r, right_nxt;
  logic             left_r, left_nxt;
  logic [AW-1:0]    fix_r, fix_nxt;
  logic [AW-1:0]    nsize_r, nsize_nxt;
  logic             old_last_r, old_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ffha_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   addr_r, addr_nxt;

  // fields of the header just read
  logic          rd_start, rd_alloc, rd_last;
  logic [AW-1:0] rd_size, rd_prev;
  logic [CW-1:0] rd_size_w, req_w, in_req_w, in_ptr_w;

  assign rd_start  = rdata_r[B_START];
  assign rd_alloc  = rdata_r[B_ALLOC];
  assign rd_last   = rdata_r[B_LAST];
  assign rd_size   = rdata_r[2*AW-1:AW];
  assign rd_prev   = rdata_r[AW-1:0];
  assign rd_size_w = CW'(rd_size);
  assign req_w     = CW'(req_r);
  assign in_req_w  = CW'(in_request_size);
  assign in_ptr_w  = CW'(in_pointer);

  // decisions shared by next-state and datapath
  logic          accept;
  logic          i_too_large, i_zero, i_null, i_invalid;
  logic          a_fit, a_split, a_walk;
  logic [CW-1:0] a_next, a_nw;
  logic [CW-1:0] w_after;
  logic          w_fix;
  logic          f_bad;
  logic [CW-1:0] f_nx;
  logic          f_right;
  logic          f_rmerge;
  logic          l_cond;
  logic [CW-1:0] l_pv;
  logic [CW-1:0] m_after;
  logic          m_fix;

  assign accept      = start && (state_r == ffha_pkg::S_IDLE);
  assign i_too_large = (in_req_w + HDR_C) > HEAP_C;
  assign i_zero      = (in_request_size == '0);
  assign i_null      = (in_pointer == '0);
  assign i_invalid   = (in_ptr_w < HDR_C) || (in_ptr_w >= HEAP_C);

  assign a_fit   = !rd_alloc && (rd_size_w >= req_w);
  assign a_nw    = cur_r + HDR_C + req_w;
  assign a_split = ((rd_size_w - req_w) >= (HDR_C + CW'(1))) && (a_nw < HEAP_C);
  assign a_next  = cur_r + HDR_C + rd_size_w;
  assign a_walk  = !rd_last && (a_next < HEAP_C);

  assign w_after = cur_r + HDR_C + CW'(nsize_r);
  assign w_fix   = !old_last_r && (w_after < HEAP_C);

  assign f_bad    = !rd_start || !rd_alloc;
  assign f_nx     = meta_r + HDR_C + rd_size_w;
  assign f_right  = !rd_last && (f_nx < HEAP_C);
  assign f_rmerge = !rd_alloc;

  assign l_cond = (meta_r != '0) && (meta_r >= (CW'(m_prev_r) + HDR_C));
  assign l_pv   = meta_r - CW'(m_prev_r) - HDR_C;

  assign m_after = meta_r + HDR_C + CW'(m_size_r);
  assign m_fix   = (left_r || right_r) && !m_last_r && (m_after < HEAP_C);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffha_pkg::S_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          if (in_command == ffha_pkg::CMD_ALLOC) begin
            if (!i_too_large && !i_zero) state_nxt = ffha_pkg::S_A_CHK;
          end else begin
            if (!i_null && !i_invalid) state_nxt = ffha_pkg::S_F_CHK;
          end
        end
      end
      ffha_pkg::S_A_CHK: begin
        if (a_fit) begin
          state_nxt = a_split ? ffha_pkg::S_A_WNEW : ffha_pkg::S_IDLE;
        end else if (!a_walk) begin
          state_nxt = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_A_WNEW: begin
        state_nxt = w_fix ? ffha_pkg::S_FIX : ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_F_CHK: begin
        if (f_bad)        state_nxt = ffha_pkg::S_IDLE;
        else if (f_right) state_nxt = ffha_pkg::S_F_RCHK;
        else              state_nxt = ffha_pkg::S_F_LREAD;
      end
      ffha_pkg::S_F_RCHK:  state_nxt = ffha_pkg::S_F_LREAD;
      ffha_pkg::S_F_LREAD: state_nxt = l_cond ? ffha_pkg::S_F_LCHK : ffha_pkg::S_F_WM;
      ffha_pkg::S_F_LCHK:  state_nxt = ffha_pkg::S_F_WM;
      ffha_pkg::S_F_WM:    state_nxt = m_fix ? ffha_pkg::S_FIX : ffha_pkg::S_IDLE;
      ffha_pkg::S_FIX:     state_nxt = ffha_pkg::S_IDLE;
      default:             state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    raddr         = '0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    cur_nxt       = cur_r;
    meta_nxt      = meta_r;
    m_size_nxt    = m_size_r;
    m_prev_nxt    = m_prev_r;
    m_last_nxt    = m_last_r;
    right_nxt     = right_r;
    left_nxt      = left_r;
    fix_nxt       = fix_r;
    nsize_nxt     = nsize_r;
    old_last_nxt  = old_last_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    case (state_r)
      ffha_pkg::S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = (clr_r == '0) ? {1'b1, 1'b0, 1'b1, INIT_SIZE, {AW{1'b0}}} : '0;
        clr_nxt = clr_r + AW'(1);
      end
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt  = in_request_size;
          addr_nxt = '0;
          if (in_command == ffha_pkg::CMD_ALLOC) begin
            cur_nxt = '0;
            raddr   = '0;
            if (i_too_large) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ffha_pkg::STAT_TOO_LARGE;
            end else if (i_zero) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ffha_pkg::STAT_ZERO;
            end
          end else begin
            meta_nxt = in_ptr_w - HDR_C;
            raddr    = meta_nxt[AW-1:0];
            if (i_null) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ffha_pkg::STAT_NULL;
            end else if (i_invalid) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ffha_pkg::STAT_INVALID;
            end
          end
        end
      end
      ffha_pkg::S_A_CHK: begin
        if (a_fit) begin
          we         = 1'b1;
          waddr      = cur_r[AW-1:0];
          wdata      = {rd_start, 1'b1, a_split ? 1'b0 : rd_last,
                        a_split ? AW'(req_r) : rd_size, rd_prev};
          addr_nxt   = ffha_pkg::ADDR_W'(cur_r + HDR_C);
          status_nxt = ffha_pkg::STAT_OK;
          if (a_split) begin
            nsize_nxt    = AW'(rd_size_w - req_w - HDR_C);
            old_last_nxt = rd_last;
            cur_nxt      = a_nw;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end else if (a_walk) begin
          cur_nxt = a_next;
          raddr   = a_next[AW-1:0];
        end else begin
          out_valid_nxt = 1'b1;
          status_nxt    = ffha_pkg::STAT_NO_FIT;
        end
      end
      ffha_pkg::S_A_WNEW: begin
        we    = 1'b1;
        waddr = cur_r[AW-1:0];
        wdata = {1'b1, 1'b0, old_last_r, nsize_r, AW'(req_r)};
        if (w_fix) begin
          raddr   = w_after[AW-1:0];
          cur_nxt = w_after;
          fix_nxt = nsize_r;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      ffha_pkg::S_F_CHK: begin
        m_size_nxt = rd_size;
        m_prev_nxt = rd_prev;
        m_last_nxt = rd_last;
        right_nxt  = 1'b0;
        left_nxt   = 1'b0;
        if (f_bad) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ffha_pkg::STAT_NOT_ALLOC;
        end else if (f_right) begin
          raddr   = f_nx[AW-1:0];
          cur_nxt = f_nx;
        end
      end
      ffha_pkg::S_F_RCHK: begin
        if (f_rmerge) begin
          m_size_nxt = AW'(CW'(m_size_r) + rd_size_w + HDR_C);
          m_last_nxt = rd_last;
          right_nxt  = 1'b1;
          we         = 1'b1;
          waddr      = cur_r[AW-1:0];
          wdata      = '0;
        end
      end
      ffha_pkg::S_F_LREAD: begin
        fix_nxt = m_size_r;
        if (l_cond) begin
          raddr   = l_pv[AW-1:0];
          cur_nxt = l_pv;
        end
      end
      ffha_pkg::S_F_LCHK: begin
        if (!rd_alloc) begin
          we       = 1'b1;
          waddr    = cur_r[AW-1:0];
          fix_nxt  = AW'(rd_size_w + CW'(m_size_r) + HDR_C);
          wdata    = {rd_start, rd_alloc, m_last_r, fix_nxt, rd_prev};
          left_nxt = 1'b1;
        end
      end
      ffha_pkg::S_F_WM: begin
        we         = 1'b1;
        waddr      = meta_r[AW-1:0];
        wdata      = left_r ? '0 : {1'b1, 1'b0, m_last_r, m_size_r, m_prev_r};
        status_nxt = ffha_pkg::STAT_OK;
        if (m_fix) begin
          raddr   = m_after[AW-1:0];
          cur_nxt = m_after;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      ffha_pkg::S_FIX: begin
        we            = 1'b1;
        waddr         = cur_r[AW-1:0];
        wdata         = {rdata_r[EW-1:AW], fix_r};
        status_nxt    = ffha_pkg::STAT_OK;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_r      <= cur_nxt;
    meta_r     <= meta_nxt;
    m_size_r   <= m_size_nxt;
    m_prev_r   <= m_prev_nxt;
    m_last_r   <= m_last_nxt;
    right_r    <= right_nxt;
    left_r     <= left_nxt;
    fix_r      <= fix_nxt;
    nsize_r    <= nsize_nxt;
    old_last_r <= old_last_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
  end

  assign busy        = (state_r != ffha_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_address = addr_r;

endmodule
`default_nettype wire
